>>> hw/rtl/ber_tlv_stream_decoder_assert.svh
// Assertion macros for the BER-TLV stream decoder checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef BER_TLV_STREAM_DECODER_ASSERT_SVH
`define BER_TLV_STREAM_DECODER_ASSERT_SVH

// clocked assertion, disabled while in reset
`define BTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication on the next cycle
`define BTD_ASSERT_NEXT(label, ante, cons, msg) \
    `BTD_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/bertlv_pkg.sv
// Shared types and constants for the BER-TLV stream decoder.
// No dependencies.
package bertlv_pkg;

    localparam int DEF_MAX_DEPTH = 8;

    // parser phases
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN   = 3'd2,
        PH_LONG  = 3'd3,
        PH_VALUE = 3'd4
    } phase_t;

    // event kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_END     = 3'd1;
    localparam logic [2:0] ERR_TAGLEN  = 3'd2;
    localparam logic [2:0] ERR_BADLEN  = 3'd3;
    localparam logic [2:0] ERR_LONGLEN = 3'd4;
    localparam logic [2:0] ERR_DEEP    = 3'd5;

    // register map
    localparam logic [2:0] ADDR_BUFLEN = 3'd0;

    // one result
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] tag;
        logic [15:0] elem_length;
        logic [3:0]  depth;
        logic        constructed;
        logic [7:0]  value_byte;
        logic        buffer_end;
        logic [2:0]  error_code;
    } event_t;

endpackage

>>> hw/rtl/ber_tlv_stream_decoder.sv
// Top level of the BER-TLV stream decoder: register port, parser, event queue.
// Depends on bertlv_pkg, bertlv_front, bertlv_queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | data_byte
//  output   | out_valid / out_ready| event_kind tag elem_length depth ...
//  register | psel penable pwrite  | paddr pwdata prdata (buffer_length at 0)
//
// One byte per cycle while in_ready is high; the parser finishes each byte in the cycle it is taken.
// Events pass a two-entry queue, so each event is registered in a queue slot before it reaches the port.
// in_ready drops only while the queue holds two events not yet taken.
// Reset or a write of buffer_length restarts parsing and clears the error.
module ber_tlv_stream_decoder #(
    parameter int MAX_DEPTH = bertlv_pkg::DEF_MAX_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [15:0] tag,
    output logic [15:0] elem_length,
    output logic [3:0]  depth,
    output logic        constructed,
    output logic [7:0]  value_byte,
    output logic        buffer_end,
    output logic [2:0]  error_code
);
    import bertlv_pkg::*;

    logic [15:0] blen_reg, blen_next;
    logic        wr_en;
    logic        clear;
    logic        full;
    logic        push;
    event_t      push_event;
    event_t      out_event;

    // register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign clear  = wr_en && (paddr == ADDR_BUFLEN);
    assign prdata = (paddr == ADDR_BUFLEN) ? {16'd0, blen_reg} : 32'd0;

    always_comb
    begin
        blen_next = clear ? pwdata[15:0] : blen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blen_reg <= '0;
        else
            blen_reg <= blen_next;
    end

    assign in_ready = !full;

    bertlv_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .buf_len    (blen_reg),
        .accept     (in_valid && in_ready),
        .data_byte  (data_byte),
        .push       (push),
        .push_event (push_event)
    );

    bertlv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (full),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_event  (out_event)
    );

    // result fields
    assign event_kind   = out_event.event_kind;
    assign tag          = out_event.tag;
    assign elem_length  = out_event.elem_length;
    assign depth        = out_event.depth;
    assign constructed  = out_event.constructed;
    assign value_byte   = out_event.value_byte;
    assign buffer_end   = out_event.buffer_end;
    assign error_code   = out_event.error_code;

endmodule

>>> hw/rtl/bertlv_front.sv
// Front end: accepts bytes and runs the TLV parser, one byte per cycle while accept is high.
// Depends on bertlv_pkg; pushes finished events into bertlv_queue.
module bertlv_front #(
    parameter int MAX_DEPTH = bertlv_pkg::DEF_MAX_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [15:0]         buf_len,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output logic                push,
    output bertlv_pkg::event_t  push_event
);
    import bertlv_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [15:0]   pos_reg, pos_next;
    phase_t        phase_reg, phase_next;
    logic [15:0]   tag_reg, tag_next;
    logic [15:0]   len_reg, len_next;
    logic [6:0]    left_reg, left_next;
    logic [2:0]    eerr_reg, eerr_next;
    logic [2:0]    ferr_reg, ferr_next;
    logic [15:0]   pend_reg, pend_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [15:0]   stack_mem [MAX_DEPTH];

    logic          stk_we;
    logic [SW-1:0] stk_idx;
    logic [15:0]   stk_val;
    logic          emit;
    event_t        ev;

    // parser step for the current byte
    always_comb
    begin
        logic [MAX_DEPTH-1:0] alive;
        logic [DW-1:0] nd;
        logic [DW-1:0] ndm1;
        logic [15:0] e;
        logic [15:0] q;
        logic [15:0] room;
        logic [7:0]  lead;
        logic        done;
        logic        cons;
        logic [1:0]  kind;
        logic [7:0]  obyte;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        eerr_next  = eerr_reg;
        ferr_next  = ferr_reg;
        pend_next  = pend_reg;
        depth_next = depth_reg;
        stk_we     = 1'b0;
        stk_idx    = '0;
        stk_val    = '0;
        emit       = 1'b0;
        ev         = '0;
        done       = 1'b0;
        cons       = 1'b0;
        kind       = KIND_NONE;
        obyte      = 8'd0;
        lead       = 8'd0;
        room       = 16'd0;

        // close levels whose end is reached; stack ends never grow inward
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            alive[i] = (DW'(i) < depth_reg) && (stack_mem[i] > pos_reg);
        end
        nd   = DW'($countones(alive));
        ndm1 = nd - DW'(1);
        e    = (nd != '0) ? stack_mem[ndm1[SW-1:0]] : buf_len;
        q    = pos_reg + 16'd1;

        if (accept && (pos_reg < buf_len))
        begin
            pos_next   = q;
            depth_next = nd;

            unique case (phase_reg)
                PH_TAG:
                begin
                    if (data_byte != 8'd0)
                    begin
                        tag_next   = {8'd0, data_byte};
                        eerr_next  = ERR_NONE;
                        len_next   = 16'd0;
                        left_next  = 7'd0;
                        phase_next = (data_byte[4:0] == 5'h1F) ? PH_TAG2 : PH_LEN;
                    end
                end
                PH_TAG2:
                begin
                    tag_next = {tag_reg[7:0], data_byte};
                    if (data_byte[7] && ferr_next == ERR_NONE)
                        ferr_next = ERR_TAGLEN;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (!data_byte[7])
                    begin
                        len_next = {9'd0, data_byte[6:0]};
                        done     = 1'b1;
                    end
                    else
                    begin
                        if (data_byte == 8'h80 || data_byte == 8'hFF)
                            eerr_next = ERR_BADLEN;
                        left_next = data_byte[6:0];
                        if (data_byte[6:0] > 7'd2)
                            eerr_next = ERR_LONGLEN;
                        len_next = 16'd0;
                        if (data_byte[6:0] == 7'd0)
                            done = 1'b1;
                        else
                            phase_next = PH_LONG;
                    end
                end
                PH_LONG:
                begin
                    len_next  = {len_reg[7:0], data_byte};
                    left_next = left_reg - 7'd1;
                    if (left_next == 7'd0)
                        done = 1'b1;
                end
                PH_VALUE:
                begin
                    kind  = KIND_VALUE;
                    obyte = data_byte;
                    if (q >= pend_reg)
                        phase_next = PH_TAG;
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase

            // enclosing end reached inside a header
            if (!done && (phase_next == PH_TAG2 || phase_next == PH_LEN ||
                          phase_next == PH_LONG) && q >= e)
            begin
                eerr_next = ERR_END;
                len_next  = 16'd0;
                done      = 1'b1;
            end

            // header complete
            if (done)
            begin
                if (eerr_next != ERR_NONE && ferr_next == ERR_NONE)
                    ferr_next = eerr_next;
                eerr_next = ERR_NONE;
                if (q > e)
                    e = q;
                room = e - q;
                if (len_next > room)
                begin
                    if (ferr_next == ERR_NONE)
                        ferr_next = ERR_END;
                    len_next = room;
                end
                lead = (tag_next > 16'h00FF) ? tag_next[15:8] : tag_next[7:0];
                cons = lead[5];
                kind = KIND_HEADER;
                phase_next = PH_TAG;
                if (cons && (nd < DW'(MAX_DEPTH)))
                begin
                    stk_we     = 1'b1;
                    stk_idx    = nd[SW-1:0];
                    stk_val    = q + len_next;
                    depth_next = nd + DW'(1);
                end
                else
                begin
                    if (cons && ferr_next == ERR_NONE)
                        ferr_next = ERR_DEEP;
                    if (len_next != 16'd0)
                    begin
                        pend_next  = q + len_next;
                        phase_next = PH_VALUE;
                    end
                end
            end

            // final byte with no other event gives an end marker
            if (kind == KIND_NONE && q == buf_len)
                kind = KIND_END;

            emit = (kind != KIND_NONE);
            ev.event_kind   = kind;
            ev.tag          = (kind == KIND_HEADER) ? tag_next : 16'd0;
            ev.elem_length  = (kind == KIND_HEADER) ? len_next : 16'd0;
            ev.depth        = 4'(nd);
            ev.constructed  = (kind == KIND_HEADER) ? cons : 1'b0;
            ev.value_byte   = obyte;
            ev.buffer_end   = (q == buf_len);
            ev.error_code   = ferr_next;
        end
    end

    assign push       = emit;
    assign push_event = ev;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            eerr_reg  <= ERR_NONE;
            ferr_reg  <= ERR_NONE;
            pend_reg  <= '0;
            depth_reg <= '0;
        end
        else if (clear)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            eerr_reg  <= ERR_NONE;
            ferr_reg  <= ERR_NONE;
            pend_reg  <= '0;
            depth_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            eerr_reg  <= eerr_next;
            ferr_reg  <= ferr_next;
            pend_reg  <= pend_next;
            depth_reg <= depth_next;
        end
    end

    // end-position stack, entries above the depth are never read
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_idx] <= stk_val;
    end

endmodule

>>> hw/rtl/bertlv_queue.sv
// Back end: two-entry event queue between parser and output port.
// Depends on bertlv_pkg.
module bertlv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bertlv_pkg::event_t  push_event,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output bertlv_pkg::event_t  out_event
);
    import bertlv_pkg::*;

    event_t     slot_mem [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign out_event = slot_mem[rd_reg];

    // pointer and count update
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_reg] <= push_event;
    end

endmodule

>>> hw/rtl/bertlv_checker.sv
// Port-level checks for the BER-TLV stream decoder, bound to the top level.
// Depends on ber_tlv_stream_decoder_assert.svh and bertlv_pkg.
`include "ber_tlv_stream_decoder_assert.svh"

module bertlv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_kind,
    input logic [15:0] tag,
    input logic [15:0] elem_length,
    input logic        constructed,
    input logic [7:0]  value_byte
);
    import bertlv_pkg::*;

    // a stalled result stays offered
    `BTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    // no empty kind reaches the port
    `BTD_ASSERT(a_kind_ok, out_valid |-> event_kind != KIND_NONE, "bad event kind")
    // header fields only on headers
    `BTD_ASSERT(a_hdr_zero, out_valid && event_kind != KIND_HEADER |-> tag == 16'd0 && elem_length == 16'd0 && constructed == 1'b0, "header fields on non-header")
    // value byte only on value events
    `BTD_ASSERT(a_val_zero, out_valid && event_kind != KIND_VALUE |-> value_byte == 8'd0, "value byte on non-value")

endmodule

bind ber_tlv_stream_decoder bertlv_checker u_chk (.*);
